FILE: sv/asvg_pkg.sv
// Shared types, constants and helpers of the argument seed value generator.
`default_nettype none

package asvg_pkg;

    // Mixer constants
    localparam logic [63:0] MIX_INIT_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_INIT_ADD = 64'h0000_0000_0123_4567;
    localparam logic [63:0] MIX_MUL      = 64'hFF51_AFD7_ED55_8CCD;
    localparam int unsigned MIX_SHIFT    = 33;

    // Stack slots are 256 bytes apart
    localparam int unsigned SLOT_SHIFT   = 8;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W        = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SBASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SSIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEN    = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_ZERO   = 3'd0;
    localparam logic [2:0] KIND_ONE    = 3'd1;
    localparam logic [2:0] KIND_U16MAX = 3'd2;
    localparam logic [2:0] KIND_I16MAX = 3'd3;
    localparam logic [2:0] KIND_I16MIN = 3'd4;
    localparam logic [2:0] KIND_IMAGE  = 3'd5;
    localparam logic [2:0] KIND_STACK  = 3'd6;
    localparam logic [2:0] KIND_MIXED  = 3'd7;

    // Multiply steps of the shared 32x32 multiplier
    localparam logic [1:0] MSTEP_LL = 2'd0;
    localparam logic [1:0] MSTEP_LH = 2'd1;
    localparam logic [1:0] MSTEP_HL = 2'd2;

    typedef struct packed {
        logic [63:0] seed;
        logic [63:0] img_addr;
        logic [63:0] stk_base;
        logic [63:0] stk_bytes;
        logic [31:0] corpus_length;
    } cfg_t;

    typedef struct packed {
        logic       capture;   // request accepted this cycle
        logic       restart;   // accepted request restarts the corpus
        logic       mul_en;    // run one multiply step
        logic [1:0] mul_step;  // which partial product
        logic       mul_init;  // use the seed constants
        logic       chain;     // feed xor-shifted product back as operand
        logic       commit;    // finish item and load the output register
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;        // output register full and not taken
    } dp_status_t;

    // Xor-shift step of the mixer
    function automatic logic [63:0] mix_xs(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

`default_nettype wire

FILE: sv/argument_seed_value_generator_unit.sv
// Top level of the argument seed value generator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready  | restart
//  out     | output    | out_valid / out_ready| value, kind, last
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item runs the multiply steps and then a finish step that loads the output register:
// the shared 32x32 multiplier needs three steps per 64-bit constant multiply, and
// a restart adds the seed multiply and a chain step to feed the product back.
// Requests are taken one at a time; a waiting result stalls the finish step only.
// Reset is asynchronous, active low, and clears the mixer, index, slot counter and
// configuration, but sets the corpus length to 1; cfg_ready is always high.
`default_nettype none

module argument_seed_value_generator_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          restart,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [63:0]                        value,
    output logic [2:0]                         kind,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [asvg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data
);
    import asvg_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    asvg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asvg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .status   (status),
        .cmd      (cmd)
    );

    asvg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .kind      (kind),
        .last      (last)
    );

endmodule

`default_nettype wire

FILE: sv/asvg_cfg.sv
// Configuration register file of the argument seed value generator.
`default_nettype none

module asvg_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [asvg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    output asvg_pkg::cfg_t                     cfg
);
    import asvg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index of a write request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEED:  cfg_next.seed          = cfg_data;
                CFG_IMAGE: cfg_next.img_addr      = cfg_data;
                CFG_SBASE: cfg_next.stk_base      = cfg_data;
                CFG_SSIZE: cfg_next.stk_bytes     = cfg_data;
                CFG_CLEN:  cfg_next.corpus_length = cfg_data[31:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed          <= '0;
            cfg_reg.img_addr      <= '0;
            cfg_reg.stk_base      <= '0;
            cfg_reg.stk_bytes     <= '0;
            cfg_reg.corpus_length <= 32'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/asvg_ctrl.sv
// Sequencing state machine of the argument seed value generator.
`default_nettype none

module asvg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                restart,
    input  wire asvg_pkg::dp_status_t status,
    output asvg_pkg::dp_cmd_t        cmd
);
    import asvg_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT0  = 4'd1;
    localparam logic [3:0] ST_INIT1  = 4'd2;
    localparam logic [3:0] ST_INIT2  = 4'd3;
    localparam logic [3:0] ST_CHAIN  = 4'd4;
    localparam logic [3:0] ST_MUL0   = 4'd5;
    localparam logic [3:0] ST_MUL1   = 4'd6;
    localparam logic [3:0] ST_MUL2   = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Issue commands and advance the sequence
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.restart = restart;
                    state_next  = restart ? ST_INIT0 : ST_MUL0;
                end
            end
            ST_INIT0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_init = 1'b1;
                cmd.mul_step = MSTEP_LL;
                state_next   = ST_INIT1;
            end
            ST_INIT1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_init = 1'b1;
                cmd.mul_step = MSTEP_LH;
                state_next   = ST_INIT2;
            end
            ST_INIT2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_init = 1'b1;
                cmd.mul_step = MSTEP_HL;
                state_next   = ST_CHAIN;
            end
            ST_CHAIN:
            begin
                cmd.chain  = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MSTEP_LL;
                state_next   = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MSTEP_LH;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MSTEP_HL;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/asvg_dp.sv
// Mixer, stack slot and value selection datapath of the generator.
`default_nettype none

module asvg_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire asvg_pkg::cfg_t       cfg,
    input  wire asvg_pkg::dp_cmd_t    cmd,
    output asvg_pkg::dp_status_t      status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [63:0]               value,
    output logic [2:0]                kind,
    output logic                      last
);
    import asvg_pkg::*;

    // Generator state
    logic [63:0] mix_reg;
    logic [31:0] index_reg;
    logic [31:0] slot_reg;

    // Multiply operand and accumulator
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;

    // Stack pipeline
    logic        mapped_reg;
    logic [63:0] mid_reg;
    logic [55:0] slots_m1_reg;
    logic [31:0] slot_sel_reg;
    logic [63:0] stack_ptr_reg;
    logic [31:0] slot_nx_reg;

    // Output register
    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [2:0]  kind_reg;
    logic        last_reg;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] mixed;

    logic [64:0] stk_top;
    logic [63:0] stack_half;
    logic [63:0] stack_span_m1;
    logic [32:0] slot_inc;

    logic [2:0]  sel;
    logic [63:0] value_next;
    logic [2:0]  kind_next;
    logic [32:0] index_inc;

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;

    // Select one 32x32 partial product per step
    assign mul_const = cmd.mul_init ? MIX_INIT_MUL : MIX_MUL;
    assign mul_a     = (cmd.mul_step == MSTEP_HL) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b     = (cmd.mul_step == MSTEP_LH) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = 64'(mul_a) * 64'(mul_b);

    // Accumulate the low 64 bits of the product
    always_comb
    begin
        if (cmd.mul_step == MSTEP_LL)
        begin
            acc_next = prod + (cmd.mul_init ? MIX_INIT_ADD : 64'd0);
        end
        else
        begin
            acc_next = acc_reg + {prod[31:0], 32'd0};
        end
    end

    assign mixed = mix_xs(acc_reg);

    // Stack bounds from the configuration
    assign stk_top       = {1'b0, cfg.stk_base} + {1'b0, cfg.stk_bytes};
    assign stack_half    = cfg.stk_bytes >> 1;
    assign stack_span_m1 = cfg.stk_bytes - stack_half - 64'd1;
    assign slot_inc      = {1'b0, slot_sel_reg} + 33'd1;

    // Pick the value by the item index, offset by the low seed bits
    assign sel       = cfg.seed[2:0] + index_reg[2:0];
    assign index_inc = {1'b0, index_reg} + 33'd1;

    always_comb
    begin
        unique case (sel)
            KIND_ZERO:
            begin
                value_next = 64'd0;
                kind_next  = KIND_ZERO;
            end
            KIND_ONE:
            begin
                value_next = 64'd1;
                kind_next  = KIND_ONE;
            end
            KIND_U16MAX:
            begin
                value_next = 64'h0000_0000_0000_FFFF;
                kind_next  = KIND_U16MAX;
            end
            KIND_I16MAX:
            begin
                value_next = 64'h0000_0000_0000_7FFF;
                kind_next  = KIND_I16MAX;
            end
            KIND_I16MIN:
            begin
                value_next = 64'hFFFF_FFFF_FFFF_8000;
                kind_next  = KIND_I16MIN;
            end
            KIND_IMAGE:
            begin
                value_next = cfg.img_addr;
                kind_next  = KIND_IMAGE;
            end
            KIND_STACK:
            begin
                // Fall back to the mixed value on an unmapped stack
                value_next = mapped_reg ? stack_ptr_reg : mixed;
                kind_next  = mapped_reg ? KIND_STACK : KIND_MIXED;
            end
            default:
            begin
                value_next = mixed;
                kind_next  = KIND_MIXED;
            end
        endcase
    end

    // Advance the mixer operand and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= cmd.restart ? cfg.seed : mix_xs(mix_reg);
        end
        else if (cmd.chain)
        begin
            x_reg <= mixed;
        end
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Run the stack slot stages alongside the multiply steps
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                MSTEP_LL:
                begin
                    mapped_reg   <= (cfg.stk_bytes != 64'd0) && !stk_top[64];
                    mid_reg      <= cfg.stk_base + stack_half;
                    slots_m1_reg <= (cfg.stk_bytes != 64'd0 && !stk_top[64])
                                    ? stack_span_m1[63:SLOT_SHIFT] : 56'd0;
                end
                MSTEP_LH:
                begin
                    slot_sel_reg <= ({24'd0, slot_reg} <= slots_m1_reg) ? slot_reg : 32'd0;
                end
                default:
                begin
                    stack_ptr_reg <= mid_reg + {24'd0, slot_sel_reg, 8'd0};
                    slot_nx_reg   <= ({23'd0, slot_inc} > slots_m1_reg)
                                     ? 32'd0 : slot_inc[31:0];
                end
            endcase
        end
    end

    // Update the generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg   <= '0;
            index_reg <= '0;
            slot_reg  <= '0;
        end
        else if (cmd.capture && cmd.restart)
        begin
            index_reg <= '0;
            slot_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            mix_reg   <= mixed;
            index_reg <= index_inc[31:0];
            slot_reg  <= slot_nx_reg;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            value_reg <= value_next;
            kind_reg  <= kind_next;
            last_reg  <= (index_inc == {1'b0, cfg.corpus_length});
        end
    end

endmodule

`default_nettype wire
